// ----- rtl/cau_pkg.sv -----
// Shared types and constants of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  // Q8.24 number format and power limit
  localparam int FracBits = 24;
  localparam int MaxPower = 16;

  // Quotient bits produced by the divider, one per step
  localparam int DivSteps = 32;
  localparam int DivSh    = 32 - FracBits;

  localparam int ExpW     = 5;
  localparam int PowCntW  = $clog2(MaxPower);
  localparam int StepW    = $clog2(DivSteps);
  localparam int CntW     = (PowCntW > StepW) ? PowCntW : StepW;

  localparam logic [31:0] ResMax = 32'h7fff_ffff;
  localparam logic [31:0] ResMin = 32'h8000_0000;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_MUL   = 4'd2,
    KIND_DIV   = 4'd3,
    KIND_POW   = 4'd4,
    KIND_CONJ  = 4'd5,
    KIND_ABSRE = 4'd6,
    KIND_ABSIM = 4'd7,
    KIND_MAG2  = 4'd8
  } kind_e;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_LOAD     = 4'd1,
    CMD_SIMPLE   = 4'd2,
    CMD_DEN_PROD = 4'd3,
    CMD_DEN_SUM  = 4'd4,
    CMD_PROD     = 4'd5,
    CMD_SUM      = 4'd6,
    CMD_ABS      = 4'd7,
    CMD_INIT     = 4'd8,
    CMD_STEP     = 4'd9,
    CMD_FIN      = 4'd10
  } dp_cmd_e;

endpackage

`default_nettype wire

// ----- rtl/complex_arithmetic_unit_top.sv -----
// Top level of the complex arithmetic unit: controller plus datapath.
`default_nettype none

// Complex ALU on signed Q8.24 parts: add, subtract, multiply, divide, power,
// conjugate, absolute real or imaginary part, squared magnitude.
// Input: drive kind_i, the operands and exponent_i with start high; the
//   transfer happens at a rising edge where start is high and busy is low.
//   Operands are captured at that edge and need not be held afterwards.
// Output: done_o is high for exactly one cycle with res_re_o, res_im_o,
//   overflow_o and div_zero_o; the receiver must take the transfer then,
//   it cannot stall the block. One result per accepted item.
// Steps from the accept edge to the strobe:
//   add, sub, conj, abs, unused kinds, power with exponent <= 1: simple step
//   multiply, squared magnitude: a multiply pass, then a sum
//   power with n = min(exponent, 16) >= 2: n-1 multiply passes through the
//     four shared 32x32 multipliers, each followed by a sum
//   divide: denominator, numerator, absolute values, radix-2 divider with
//     one quotient bit per cycle on both parts at once; zero divisor skips it
// busy stays high until the strobe; a new item is taken only after it.
// Reset (rst_ni low, asynchronous) returns the controller to idle; any item
//   in flight is dropped and no strobe follows.

module complex_arithmetic_unit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  input  logic [4:0]         exponent_i,
  output logic               done_o,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               overflow_o,
  output logic               div_zero_o
);
  import cau_pkg::*;

  dp_cmd_e cmd;
  logic    den_zero;

  // Sequence the operation; capture happens on the load command
  cau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .kind_i     (kind_i),
    .exponent_i (exponent_i),
    .den_zero_i (den_zero),
    .busy_o     (busy),
    .done_o     (done_o),
    .cmd_o      (cmd)
  );

  // Hold operands, multiply, divide and saturate
  cau_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .kind_i     (kind_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .den_zero_o (den_zero),
    .res_re_o   (res_re_o),
    .res_im_o   (res_im_o),
    .overflow_o (overflow_o),
    .div_zero_o (div_zero_o)
  );

  // A zero divisor must give a zero result without overflow
  a_div_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && div_zero_o |-> res_re_o == '0 && res_im_o == '0 && !overflow_o)
    else $error("divide by zero result not cleared");

endmodule

`default_nettype wire

// ----- rtl/cau_dp.sv -----
// Datapath of the complex arithmetic unit: operands, multipliers, divider lanes, result.
`default_nettype none

module cau_dp (
  input  logic                  clk_i,
  input  cau_pkg::dp_cmd_e      cmd_i,
  input  logic [3:0]            kind_i,
  input  logic signed [31:0]    a_re_i,
  input  logic signed [31:0]    a_im_i,
  input  logic signed [31:0]    b_re_i,
  input  logic signed [31:0]    b_im_i,
  output logic                  den_zero_o,
  output logic signed [31:0]    res_re_o,
  output logic signed [31:0]    res_im_o,
  output logic                  overflow_o,
  output logic                  div_zero_o
);
  import cau_pkg::*;

  // floor by 2^FracBits, then saturate; returns {overflow, value}
  function automatic logic [32:0] sat_wide(logic signed [64:0] v);
    logic signed [64:0] sh;
    logic               ov;
    sh = v >>> FracBits;
    ov = ~((&sh[64:31]) | ~(|sh[64:31]));
    return ov ? {1'b1, (sh[64] ? ResMin : ResMax)} : {1'b0, sh[31:0]};
  endfunction

  function automatic logic [32:0] sat_33(logic signed [32:0] v);
    logic ov;
    ov = v[32] ^ v[31];
    return ov ? {1'b1, (v[32] ? ResMin : ResMax)} : {1'b0, v[31:0]};
  endfunction

  logic [3:0]          kind_q;
  logic signed [31:0]  a_re_q, a_im_q, b_re_q, b_im_q;
  logic signed [31:0]  r_re_q, r_im_q;
  logic signed [63:0]  prod_q [4];
  logic signed [31:0]  mx [4];
  logic signed [31:0]  my [4];
  logic [63:0]         den_q;
  logic signed [64:0]  num_q [2];
  logic                neg_q [2];
  logic                big_q [2];
  logic [63:0]         mag_q [2];
  logic [63:0]         rem_q [2];
  logic [31:0]         shf_q [2];
  logic [31:0]         quo_q [2];
  logic signed [31:0]  res_re_q, res_im_q;
  logic                ov_q, dz_q;

  logic signed [64:0]  p_x [4];
  logic signed [64:0]  sum_re, sum_im;
  logic [32:0]         sat_re, sat_im;
  logic [63:0]         den_sum;
  logic [32:0]         smp_re, smp_im;
  logic signed [32:0]  are_x, aim_x, bre_x, bim_x;

  logic signed [64:0]  num_neg [2];
  logic [63:0]         mag_d [2];
  logic                big_d [2];
  logic [64:0]         rem2 [2];
  logic [64:0]         diff [2];
  logic                ge [2];
  logic [32:0]         qneg [2];
  logic                ovl [2];
  logic [31:0]         fin_val [2];

  // Multiplier operand selection
  always_comb begin
    mx[0] = a_re_q;  mx[1] = a_im_q;  mx[2] = a_re_q;  mx[3] = a_im_q;
    my[0] = b_re_q;  my[1] = b_im_q;  my[2] = b_im_q;  my[3] = b_re_q;
    if (cmd_i == CMD_DEN_PROD) begin
      mx[0] = b_re_q;
      mx[1] = b_im_q;
    end else begin
      case (kind_q)
        KIND_POW: begin
          my[0] = r_re_q;  my[1] = r_im_q;  my[2] = r_im_q;  my[3] = r_re_q;
        end
        KIND_MAG2: begin
          my[0] = a_re_q;
          my[1] = a_im_q;
        end
        default: ;
      endcase
    end
  end

  // Combine products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p_x[i] = 65'(prod_q[i]);
    end
    sum_re  = (kind_q inside {KIND_MUL, KIND_POW}) ? p_x[0] - p_x[1] : p_x[0] + p_x[1];
    sum_im  = (kind_q == KIND_DIV) ? p_x[3] - p_x[2] : p_x[3] + p_x[2];
    sat_re  = sat_wide(sum_re);
    sat_im  = sat_wide(sum_im);
    den_sum = $unsigned(prod_q[0]) + $unsigned(prod_q[1]);
  end

  // Simple operations, no multiplier needed
  always_comb begin
    are_x = 33'(a_re_q);
    aim_x = 33'(a_im_q);
    bre_x = 33'(b_re_q);
    bim_x = 33'(b_im_q);
    smp_re = '0;
    smp_im = '0;
    case (kind_q)
      KIND_ADD: begin
        smp_re = sat_33(are_x + bre_x);
        smp_im = sat_33(aim_x + bim_x);
      end
      KIND_SUB: begin
        smp_re = sat_33(are_x - bre_x);
        smp_im = sat_33(aim_x - bim_x);
      end
      KIND_POW: begin
        smp_re = {1'b0, a_re_q};
        smp_im = {1'b0, a_im_q};
      end
      KIND_CONJ: begin
        smp_re = {1'b0, a_re_q};
        smp_im = sat_33(-aim_x);
      end
      KIND_ABSRE: begin
        smp_re = sat_33(a_re_q[31] ? -are_x : are_x);
        smp_im = {1'b0, a_im_q};
      end
      KIND_ABSIM: begin
        smp_re = {1'b0, a_re_q};
        smp_im = sat_33(a_im_q[31] ? -aim_x : aim_x);
      end
      default: ;
    endcase
  end

  // Divider lanes: lane 0 real, lane 1 imaginary
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      num_neg[i] = -num_q[i];
      mag_d[i]   = num_q[i][64] ? num_neg[i][63:0] : num_q[i][63:0];
      big_d[i]   = {{DivSh{1'b0}}, mag_q[i]} >= {den_q, {DivSh{1'b0}}};
      rem2[i]    = {rem_q[i], shf_q[i][31]};
      diff[i]    = rem2[i] - {1'b0, den_q};
      ge[i]      = rem2[i] >= {1'b0, den_q};
      qneg[i]    = 33'd0 - {1'b0, quo_q[i]};
      ovl[i]     = big_q[i] | (neg_q[i] ? (quo_q[i][31] & (|quo_q[i][30:0]))
                                        : quo_q[i][31]);
      if (dz_q) begin
        fin_val[i] = '0;
      end else if (ovl[i]) begin
        fin_val[i] = neg_q[i] ? ResMin : ResMax;
      end else begin
        fin_val[i] = neg_q[i] ? qneg[i][31:0] : quo_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        kind_q <= kind_i;
        a_re_q <= a_re_i;
        a_im_q <= a_im_i;
        b_re_q <= b_re_i;
        b_im_q <= b_im_i;
        r_re_q <= a_re_i;
        r_im_q <= a_im_i;
        ov_q   <= 1'b0;
        dz_q   <= 1'b0;
      end
      CMD_SIMPLE: begin
        res_re_q <= smp_re[31:0];
        res_im_q <= smp_im[31:0];
        ov_q     <= ov_q | smp_re[32] | smp_im[32];
      end
      CMD_DEN_PROD, CMD_PROD: begin
        for (int i = 0; i < 4; i++) begin
          prod_q[i] <= mx[i] * my[i];
        end
      end
      CMD_DEN_SUM: begin
        den_q <= den_sum;
      end
      CMD_SUM: begin
        case (kind_q)
          KIND_DIV: begin
            num_q[0] <= sum_re;
            num_q[1] <= sum_im;
          end
          KIND_POW: begin
            r_re_q   <= sat_re[31:0];
            r_im_q   <= sat_im[31:0];
            res_re_q <= sat_re[31:0];
            res_im_q <= sat_im[31:0];
            ov_q     <= ov_q | sat_re[32] | sat_im[32];
          end
          KIND_MAG2: begin
            res_re_q <= sat_re[31:0];
            res_im_q <= '0;
            ov_q     <= ov_q | sat_re[32];
          end
          default: begin
            res_re_q <= sat_re[31:0];
            res_im_q <= sat_im[31:0];
            ov_q     <= ov_q | sat_re[32] | sat_im[32];
          end
        endcase
      end
      CMD_ABS: begin
        for (int i = 0; i < 2; i++) begin
          neg_q[i] <= num_q[i][64];
          mag_q[i] <= mag_d[i];
        end
        dz_q <= (den_q == '0);
      end
      CMD_INIT: begin
        for (int i = 0; i < 2; i++) begin
          big_q[i] <= big_d[i];
          rem_q[i] <= mag_q[i] >> DivSh;
          shf_q[i] <= {mag_q[i][DivSh-1:0], {FracBits{1'b0}}};
          quo_q[i] <= '0;
        end
      end
      CMD_STEP: begin
        for (int i = 0; i < 2; i++) begin
          rem_q[i] <= ge[i] ? diff[i][63:0] : rem2[i][63:0];
          quo_q[i] <= {quo_q[i][30:0], ge[i]};
          shf_q[i] <= {shf_q[i][30:0], 1'b0};
        end
      end
      CMD_FIN: begin
        res_re_q <= fin_val[0];
        res_im_q <= fin_val[1];
        ov_q     <= ov_q | (~dz_q & (ovl[0] | ovl[1]));
      end
      default: ;
    endcase
  end

  assign den_zero_o = (den_q == '0);
  assign res_re_o   = res_re_q;
  assign res_im_o   = res_im_q;
  assign overflow_o = ov_q;
  assign div_zero_o = dz_q;

endmodule

`default_nettype wire

// ----- rtl/cau_ctrl.sv -----
// Controller of the complex arithmetic unit: sequences the datapath for each operation.
`default_nettype none

module cau_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [3:0]            kind_i,
  input  logic [4:0]            exponent_i,
  input  logic                  den_zero_i,
  output logic                  busy_o,
  output logic                  done_o,
  output cau_pkg::dp_cmd_e      cmd_o
);
  import cau_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SIMPLE   = 11'b000_0000_0010,
    S_DEN_PROD = 11'b000_0000_0100,
    S_DEN_SUM  = 11'b000_0000_1000,
    S_PROD     = 11'b000_0001_0000,
    S_SUM      = 11'b000_0010_0000,
    S_ABS      = 11'b000_0100_0000,
    S_INIT     = 11'b000_1000_0000,
    S_STEP     = 11'b001_0000_0000,
    S_FIN      = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [3:0]      kind_q, kind_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] pow_cnt;

  // Multiplications still to do: clamped exponent minus one
  always_comb begin
    if (32'(exponent_i) > MaxPower) begin
      pow_cnt = CntW'(MaxPower - 1);
    end else begin
      pow_cnt = CntW'(exponent_i - ExpW'(1));
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o  = CMD_LOAD;
          kind_d = kind_i;
          cnt_d  = pow_cnt;
          if (kind_i inside {KIND_MUL, KIND_MAG2}) begin
            state_d = S_PROD;
          end else if (kind_i == KIND_DIV) begin
            state_d = S_DEN_PROD;
          end else if (kind_i == KIND_POW && exponent_i > ExpW'(1)) begin
            state_d = S_PROD;
          end else begin
            state_d = S_SIMPLE;
          end
        end
      end
      S_SIMPLE: begin
        cmd_o   = CMD_SIMPLE;
        state_d = S_DONE;
      end
      S_DEN_PROD: begin
        cmd_o   = CMD_DEN_PROD;
        state_d = S_DEN_SUM;
      end
      S_DEN_SUM: begin
        cmd_o   = CMD_DEN_SUM;
        state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o   = CMD_PROD;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o = CMD_SUM;
        if (kind_q == KIND_DIV) begin
          state_d = S_ABS;
        end else if (kind_q == KIND_POW && cnt_q != CntW'(1)) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_PROD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ABS: begin
        cmd_o   = CMD_ABS;
        state_d = den_zero_i ? S_FIN : S_INIT;
      end
      S_INIT: begin
        cmd_o   = CMD_INIT;
        cnt_d   = CntW'(DivSteps - 1);
        state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o = CMD_STEP;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      S_FIN: begin
        cmd_o   = CMD_FIN;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("busy held after result strobe");

  a_busy_until_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && !done_o |=> busy_o)
    else $error("busy dropped without a result strobe");

endmodule

`default_nettype wire
